// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker files of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is not asserted.
`define CSVT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CSVT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/csvt_pkg.sv -----
// ----------------------------------------------------------------------------
// csvt_pkg
// Types and constants shared by the CSV field tokenizer modules.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam int POSITION_BITS = 32;
  localparam int COLUMN_BITS   = 16;
  localparam int ROW_BITS      = 32;
  localparam int CHAR_BITS     = 16;

  localparam logic [CHAR_BITS-1:0] CH_QUOTE = 16'd34;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 16'd13;
  localparam logic [CHAR_BITS-1:0] CH_LF    = 16'd10;
  localparam logic [CHAR_BITS-1:0] DELIM_RESET = 16'd44;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [COLUMN_BITS-1:0]   COL_MAX = '1;
  localparam logic [ROW_BITS-1:0]      ROW_MAX = '1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    MODE_START      = 2'd0,
    MODE_UNQUOTED   = 2'd1,
    MODE_QUOTED     = 2'd2,
    MODE_QUOTE_SEEN = 2'd3
  } field_mode_t;

  // One classified beat as it travels from the front to the back.
  typedef struct packed {
    logic op_end;
    logic bad;
    logic is_delim;
    logic is_quote;
    logic is_cr;
    logic is_lf;
  } csvt_beat_t;

  typedef struct packed {
    logic       valid;
    csvt_beat_t beat;
  } csvt_push_t;

endpackage

// ----- src/csvt_front.sv -----
// ----------------------------------------------------------------------------
// csvt_front
// Holds the delimiter register and classifies each input beat for the back.
// ----------------------------------------------------------------------------
module csvt_front import csvt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CHAR_BITS-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [CHAR_BITS-1:0] in_char_code,
  input  logic                 q_full,
  output csvt_push_t           push
);

  logic [CHAR_BITS-1:0] delim_r;
  logic [CHAR_BITS-1:0] delim_nxt;
  logic                 bad;
  logic                 is_end;

  assign cfg_ready = 1'b1;
  assign delim_nxt = (cfg_valid && cfg_ready) ? cfg_data : delim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RESET;
    end else begin
      delim_r <= delim_nxt;
    end
  end

  assign bad    = delim_r inside {CH_CR, CH_LF, CH_QUOTE};
  assign is_end = (op_t'(in_operation) == OP_END);

  assign in_ready = !q_full;

  // Characters are dropped here while the delimiter is invalid.
  always_comb begin
    push.valid         = in_valid && in_ready && (is_end || !bad);
    push.beat.op_end   = is_end;
    push.beat.bad      = bad;
    push.beat.is_delim = (in_char_code == delim_r);
    push.beat.is_quote = (in_char_code == CH_QUOTE);
    push.beat.is_cr    = (in_char_code == CH_CR);
    push.beat.is_lf    = (in_char_code == CH_LF);
  end

endmodule

// ----- src/csvt_queue.sv -----
// ----------------------------------------------------------------------------
// csvt_queue
// Short queue of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module csvt_queue import csvt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  csvt_push_t push,
  output logic       full,
  output logic       q_valid,
  output csvt_beat_t q_beat,
  input  logic       q_pop
);

  csvt_beat_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r;
  logic [QCNT_BITS-1:0] count_nxt;
  logic                 do_pop;

  assign full    = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_beat  = mem_r[rd_ptr_r];
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push.valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.beat;
    end
  end

endmodule

// ----- src/csvt_back.sv -----
// ----------------------------------------------------------------------------
// csvt_back
// Field state machine, position and column counters, and the result register.
// ----------------------------------------------------------------------------
module csvt_back import csvt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  csvt_beat_t               q_beat,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [POSITION_BITS-1:0] out_cell_start,
  output logic [POSITION_BITS-1:0] out_cell_end,
  output logic                     out_cell_quoted,
  output logic                     out_row_end,
  output logic [COLUMN_BITS-1:0]   out_column_index,
  output logic [ROW_BITS-1:0]      out_row_index,
  output logic [COLUMN_BITS-1:0]   out_max_columns,
  output logic                     out_bad_delimiter
);

  field_mode_t              mode_r, mode_nxt, eff_mode;
  logic                     crp_r, crp_nxt;
  logic [POSITION_BITS-1:0] begin_r, begin_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_inc;
  logic [COLUMN_BITS-1:0]   cols_r, cols_nxt, cols_inc;
  logic [ROW_BITS-1:0]      rows_r, rows_nxt;
  logic [COLUMN_BITS-1:0]   widest_r, widest_nxt, widest_upd;
  logic                     out_valid_r, out_valid_nxt;

  logic [POSITION_BITS-1:0] start_r;
  logic [POSITION_BITS-1:0] end_r;
  logic                     quoted_r;
  logic                     row_end_r;
  logic [COLUMN_BITS-1:0]   col_idx_r;
  logic [ROW_BITS-1:0]      row_idx_r;
  logic [COLUMN_BITS-1:0]   max_cols_r;
  logic                     bad_r;

  logic                     fire;
  logic                     emit;
  logic                     em_bad;
  logic                     em_quoted;
  logic                     em_row;
  logic [POSITION_BITS-1:0] em_end;
  logic                     adv_field;
  logic                     clear;

  assign fire     = q_valid && (!out_valid_r || out_ready);
  assign q_pop    = fire;
  assign pos_inc  = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
  assign cols_inc = (cols_r == COL_MAX) ? cols_r : cols_r + 1'b1;
  assign widest_upd = (cols_inc > widest_r) ? cols_inc : widest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_START;
      crp_r       <= 1'b0;
      begin_r     <= '0;
      pos_r       <= '0;
      cols_r      <= '0;
      rows_r      <= '0;
      widest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      crp_r       <= crp_nxt;
      begin_r     <= begin_nxt;
      pos_r       <= pos_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      widest_r    <= widest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    crp_nxt    = crp_r;
    begin_nxt  = begin_r;
    pos_nxt    = pos_r;
    cols_nxt   = cols_r;
    rows_nxt   = rows_r;
    widest_nxt = widest_r;
    eff_mode   = mode_r;
    emit       = 1'b0;
    em_bad     = 1'b0;
    em_quoted  = 1'b0;
    em_row     = 1'b0;
    em_end     = pos_r;
    adv_field  = 1'b0;
    clear      = 1'b0;

    if (fire) begin
      if (q_beat.op_end) begin
        if (q_beat.bad) begin
          em_bad = 1'b1;
        end else begin
          emit      = 1'b1;
          em_quoted = (mode_r == MODE_QUOTE_SEEN) && !crp_r;
          em_row    = 1'b1;
        end
        clear = 1'b1;
      end else begin
        pos_nxt = pos_inc;
        crp_nxt = 1'b0;
        if (crp_r && q_beat.is_lf) begin
          emit      = 1'b1;
          em_end    = (pos_r != '0) ? pos_r - 1'b1 : '0;
          em_quoted = (mode_r == MODE_QUOTE_SEEN);
          em_row    = 1'b1;
          adv_field = 1'b1;
        end else begin
          // A CR after a closing quote that is not followed by LF is dirty text.
          if (crp_r && mode_r == MODE_QUOTE_SEEN) begin
            eff_mode = MODE_UNQUOTED;
          end
          mode_nxt = eff_mode;
          case (eff_mode)
            MODE_START: begin
              if (q_beat.is_delim) begin
                emit      = 1'b1;
                adv_field = 1'b1;
              end else if (q_beat.is_quote) begin
                begin_nxt = pos_r;
                mode_nxt  = MODE_QUOTED;
              end else if (q_beat.is_cr) begin
                crp_nxt  = 1'b1;
                mode_nxt = MODE_UNQUOTED;
              end else if (q_beat.is_lf) begin
                emit      = 1'b1;
                em_row    = 1'b1;
                adv_field = 1'b1;
              end else begin
                mode_nxt = MODE_UNQUOTED;
              end
            end
            MODE_UNQUOTED: begin
              if (q_beat.is_delim) begin
                emit      = 1'b1;
                adv_field = 1'b1;
              end else if (q_beat.is_cr) begin
                crp_nxt = 1'b1;
              end else if (q_beat.is_lf) begin
                emit      = 1'b1;
                em_row    = 1'b1;
                adv_field = 1'b1;
              end
            end
            MODE_QUOTED: begin
              if (q_beat.is_quote) begin
                mode_nxt = MODE_QUOTE_SEEN;
              end
            end
            default: begin
              if (q_beat.is_quote) begin
                mode_nxt = MODE_QUOTED;
              end else if (q_beat.is_delim) begin
                emit      = 1'b1;
                em_quoted = 1'b1;
                adv_field = 1'b1;
              end else if (q_beat.is_cr) begin
                crp_nxt = 1'b1;
              end else if (q_beat.is_lf) begin
                emit      = 1'b1;
                em_quoted = 1'b1;
                em_row    = 1'b1;
                adv_field = 1'b1;
              end else begin
                mode_nxt = MODE_UNQUOTED;
              end
            end
          endcase
        end
      end
    end

    if (emit) begin
      cols_nxt = cols_inc;
      if (em_row) begin
        widest_nxt = widest_upd;
        cols_nxt   = '0;
        rows_nxt   = (rows_r == ROW_MAX) ? rows_r : rows_r + 1'b1;
      end
    end
    if (adv_field) begin
      begin_nxt = pos_inc;
      mode_nxt  = MODE_START;
    end
    if (clear) begin
      mode_nxt   = MODE_START;
      crp_nxt    = 1'b0;
      begin_nxt  = '0;
      pos_nxt    = '0;
      cols_nxt   = '0;
      rows_nxt   = '0;
      widest_nxt = '0;
    end

    if (fire && (emit || em_bad)) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && em_bad) begin
      start_r    <= '0;
      end_r      <= '0;
      quoted_r   <= 1'b0;
      row_end_r  <= 1'b0;
      col_idx_r  <= '0;
      row_idx_r  <= '0;
      max_cols_r <= '0;
      bad_r      <= 1'b1;
    end else if (fire && emit) begin
      start_r    <= begin_r;
      end_r      <= em_end;
      quoted_r   <= em_quoted;
      row_end_r  <= em_row;
      col_idx_r  <= cols_r;
      row_idx_r  <= rows_r;
      max_cols_r <= em_row ? widest_upd : widest_r;
      bad_r      <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_start    = start_r;
  assign out_cell_end      = end_r;
  assign out_cell_quoted   = quoted_r;
  assign out_row_end       = row_end_r;
  assign out_column_index  = col_idx_r;
  assign out_row_index     = row_idx_r;
  assign out_max_columns   = max_cols_r;
  assign out_bad_delimiter = bad_r;

endmodule

// ----- src/csv_field_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// csv_field_tokenizer_core
// Streaming CSV field splitter: one UTF-16 character per beat, one result
// beat per completed field.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one character (operation 0) or the end of the
// document (operation 1). A field ends at the delimiter, at LF, at CRLF and at
// the end marker, and each ending gives one result beat with its start and
// end positions, quoted flag, row end flag, column, row and widest row so far.
// The cfg channel writes the delimiter (reset 44) and is always ready; write
// it only while no beats are in flight. An invalid delimiter (CR, LF or quote)
// drops character beats and makes the end marker return one error beat.
// Throughput is one beat per cycle on both channels while out_ready is high;
// the front classifies a beat into a two-entry queue and the back runs the field
// state machine once per cycle into a result register. An accepted beat waits
// in the queue and its result then in the result register. When the receiver
// stalls, the result register holds and the queue fills, after which in_ready
// falls. Reset restores control state, delimiter and queue, not the result fields.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_core import csvt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CHAR_BITS-1:0]     cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_operation,
  input  logic [CHAR_BITS-1:0]     in_char_code,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [POSITION_BITS-1:0] out_cell_start,
  output logic [POSITION_BITS-1:0] out_cell_end,
  output logic                     out_cell_quoted,
  output logic                     out_row_end,
  output logic [COLUMN_BITS-1:0]   out_column_index,
  output logic [ROW_BITS-1:0]      out_row_index,
  output logic [COLUMN_BITS-1:0]   out_max_columns,
  output logic                     out_bad_delimiter
);

  csvt_push_t push;
  logic       q_full;
  logic       q_valid;
  csvt_beat_t q_beat;
  logic       q_pop;

  csvt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .push         (push)
  );

  csvt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (q_full),
    .q_valid (q_valid),
    .q_beat  (q_beat),
    .q_pop   (q_pop)
  );

  csvt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_beat            (q_beat),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cell_start    (out_cell_start),
    .out_cell_end      (out_cell_end),
    .out_cell_quoted   (out_cell_quoted),
    .out_row_end       (out_row_end),
    .out_column_index  (out_column_index),
    .out_row_index     (out_row_index),
    .out_max_columns   (out_max_columns),
    .out_bad_delimiter (out_bad_delimiter)
  );

endmodule

// ----- src/csvt_checker.sv -----
// ----------------------------------------------------------------------------
// csvt_checker
// Port level checks for the CSV field tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csvt_checker import csvt_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [POSITION_BITS-1:0] out_cell_start,
  input logic [POSITION_BITS-1:0] out_cell_end,
  input logic                     out_cell_quoted,
  input logic                     out_row_end,
  input logic [COLUMN_BITS-1:0]   out_column_index,
  input logic [ROW_BITS-1:0]      out_row_index,
  input logic [COLUMN_BITS-1:0]   out_max_columns,
  input logic                     out_bad_delimiter
);

  `CSVT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "Result beat right after reset.")
  `CSVT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "Result beat dropped while stalled.")
  `CSVT_ASSERT(a_err_clean, out_valid && out_bad_delimiter |-> out_cell_start == '0 && out_cell_end == '0 && !out_cell_quoted && !out_row_end && out_column_index == '0 && out_row_index == '0 && out_max_columns == '0, "Error beat carries field data.")
  `CSVT_ASSERT(a_range_order, out_valid |-> out_cell_end >= out_cell_start, "Field ends before it starts.")
  `CSVT_ASSERT(a_widest_row, out_valid && out_row_end && !out_bad_delimiter |-> out_max_columns > out_column_index || out_max_columns == COL_MAX, "Widest row is narrower than the row just ended.")

endmodule

bind csv_field_tokenizer_core csvt_checker u_csvt_checker (.*);
